>>> hw/rtl/cpq_pkg.sv
package cpq_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_W    = 24;
  localparam int MAG_W      = COORD_W - 1;
  localparam int REG_W      = 10;
  localparam int ID_W       = 6;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  // coordinate differences and bounds carry one extra bit
  localparam int DIFF_W     = COORD_W + 1;
  // square of a DIFF_W signed value, always non-negative
  localparam int SQ_W       = 2 * COORD_W + 1;
  localparam int SUM_W      = SQ_W + 1;

  // region passes: below, centre, above
  localparam logic [1:0] LAST_PASS = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD      = 2'd0,
    ACT_QUERY     = 2'd1,
    ACT_CLR_MARKS = 2'd2,
    ACT_CLR_STORE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R2,
    ST_RD,
    ST_CHK,
    ST_SQX,
    ST_SQZ,
    ST_CMP,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t                     action;
    logic signed [COORD_W-1:0]   pos_x;
    logic signed [COORD_W-1:0]   pos_y;
    logic signed [COORD_W-1:0]   pos_z;
    logic        [MAG_W-1:0]     radius;
    logic        [MAG_W-1:0]     height;
    logic        [REG_W-1:0]     region;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic signed [COORD_W-1:0]   point_z;
    logic        [ID_W-1:0]      point_id;
    logic                        found;
    logic                        last;
    logic                        full_error;
  } out_t;

  typedef struct packed {
    logic        [REG_W-1:0]     region;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
    logic signed [COORD_W-1:0]   z;
  } entry_t;

endpackage

>>> hw/rtl/cylinder_point_query.sv
// Point store with cylinder search. Up to cpq_pkg::MAX_POINTS points are kept in a
// memory with one write and one read port, each with a region number and an
// active mark held in flip-flops. A load, a mark clear or a store clear is taken
// in IDLE, passes through DONE and its single result is registered out once the
// output is free. A query first squares the radius in the shared squaring
// multiplier, then walks every stored point three times (region-1, region,
// region+1). Each point visit reads the memory and then checks region, mark and
// height; a point that passes the check goes through the squaring multiplier
// (dx^2, dz^2, sum and compare) and then records the hit, which may wait while
// the output is stalled. A point matches the region of one pass at most. Hits
// are held one result behind so the final one can carry last; a query with no
// hit returns a single result with found low. New transactions are stalled
// while an item is in progress.
module cylinder_point_query (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cpq_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cpq_pkg::out_t  out_data
);

  cpq_pkg::state_t state_r, state_nxt;

  logic [cpq_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [cpq_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [1:0]                      pass_r, pass_nxt;
  logic [cpq_pkg::MAX_POINTS-1:0]  act_r, act_nxt;
  logic                            pend_v_r, pend_v_nxt;
  cpq_pkg::out_t                   pend_r, pend_nxt;
  logic                            out_valid_r, out_valid_nxt;
  cpq_pkg::out_t                   out_r, out_nxt;

  logic signed [cpq_pkg::COORD_W-1:0] qx_r, qy_r, qz_r;
  logic signed [cpq_pkg::DIFF_W-1:0]  qtop_r;
  logic        [cpq_pkg::REG_W-1:0]   qreg_r;
  logic        [cpq_pkg::SQ_W-1:0]    r2_r, prod_r, acc_r;
  logic signed [cpq_pkg::DIFF_W-1:0]  dx_r, dz_r;

  cpq_pkg::entry_t mem [cpq_pkg::MAX_POINTS];
  cpq_pkg::entry_t mem_q_r;

  logic accept, full, out_free, emit_go;
  logic cand, hit, last_idx, scan_end, advance;
  logic [cpq_pkg::REG_W:0]            tgt;
  logic signed [cpq_pkg::DIFF_W-1:0]  ey_ext, dx_w, dz_w;
  logic signed [cpq_pkg::DIFF_W-1:0]  mul_a;
  logic signed [2*cpq_pkg::DIFF_W-1:0] sq_full;
  logic [cpq_pkg::SUM_W-1:0]          dist2;
  cpq_pkg::entry_t                    wr_entry;

  assign in_stall  = (state_r != cpq_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_go   = !pend_v_r || out_free;
  assign full      = (count_r == cpq_pkg::CNT_W'(cpq_pkg::MAX_POINTS));

  // point store
  assign wr_entry = '{region: in_data.region, x: in_data.pos_x,
                      y: in_data.pos_y, z: in_data.pos_z};

  always_ff @(posedge clk) begin
    if (accept && in_data.action == cpq_pkg::ACT_LOAD && !full) begin
      mem[count_r[cpq_pkg::IDX_W-1:0]] <= wr_entry;
    end
    mem_q_r <= mem[idx_r];
  end

  // shared squaring unit, registered output
  always_comb begin
    case (state_r)
      cpq_pkg::ST_IDLE: mul_a = $signed({2'b00, in_data.radius});
      cpq_pkg::ST_SQZ:  mul_a = dz_r;
      default:          mul_a = dx_r;
    endcase
  end

  assign sq_full = mul_a * mul_a;

  // candidate check on the freshly read entry
  assign tgt = {1'b0, qreg_r} + (cpq_pkg::REG_W + 1)'(pass_r)
             - (cpq_pkg::REG_W + 1)'(1);
  assign ey_ext = cpq_pkg::DIFF_W'(mem_q_r.y);
  assign dx_w   = cpq_pkg::DIFF_W'(mem_q_r.x) - cpq_pkg::DIFF_W'(qx_r);
  assign dz_w   = cpq_pkg::DIFF_W'(mem_q_r.z) - cpq_pkg::DIFF_W'(qz_r);
  // top bit of tgt flags a region outside the range (below 0 or past the top)
  assign cand = !tgt[cpq_pkg::REG_W] && (mem_q_r.region == tgt[cpq_pkg::REG_W-1:0])
             && !act_r[idx_r] && (mem_q_r.y >= qy_r) && (ey_ext <= qtop_r);

  assign dist2 = cpq_pkg::SUM_W'(acc_r) + cpq_pkg::SUM_W'(prod_r);
  assign hit   = (dist2 <= cpq_pkg::SUM_W'(r2_r));

  assign last_idx = (cpq_pkg::CNT_W'(idx_r) == count_r - cpq_pkg::CNT_W'(1));
  assign scan_end = last_idx && (pass_r == cpq_pkg::LAST_PASS);
  assign advance  = ((state_r == cpq_pkg::ST_CHK) && !cand)
                 || ((state_r == cpq_pkg::ST_CMP) && !hit)
                 || ((state_r == cpq_pkg::ST_EMIT) && emit_go);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpq_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.action == cpq_pkg::ACT_QUERY) ? cpq_pkg::ST_R2
                                                             : cpq_pkg::ST_DONE;
        end
      end
      cpq_pkg::ST_R2: begin
        state_nxt = (count_r == '0) ? cpq_pkg::ST_DONE : cpq_pkg::ST_RD;
      end
      cpq_pkg::ST_RD:  state_nxt = cpq_pkg::ST_CHK;
      cpq_pkg::ST_CHK: begin
        if (cand) begin
          state_nxt = cpq_pkg::ST_SQX;
        end else begin
          state_nxt = scan_end ? cpq_pkg::ST_DONE : cpq_pkg::ST_RD;
        end
      end
      cpq_pkg::ST_SQX: state_nxt = cpq_pkg::ST_SQZ;
      cpq_pkg::ST_SQZ: state_nxt = cpq_pkg::ST_CMP;
      cpq_pkg::ST_CMP: begin
        if (hit) begin
          state_nxt = cpq_pkg::ST_EMIT;
        end else begin
          state_nxt = scan_end ? cpq_pkg::ST_DONE : cpq_pkg::ST_RD;
        end
      end
      cpq_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = scan_end ? cpq_pkg::ST_DONE : cpq_pkg::ST_RD;
        end
      end
      cpq_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = cpq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpq_pkg::ST_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    act_nxt       = act_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      idx_nxt  = '0;
      pass_nxt = '0;
      pend_nxt = '0;
      pend_nxt.last = 1'b1;
      pend_v_nxt = (in_data.action != cpq_pkg::ACT_QUERY);
      case (in_data.action)
        cpq_pkg::ACT_LOAD: begin
          if (full) begin
            pend_nxt.full_error = 1'b1;
          end else begin
            pend_nxt.point_id = cpq_pkg::ID_W'(count_r);
            count_nxt = count_r + cpq_pkg::CNT_W'(1);
            act_nxt[count_r[cpq_pkg::IDX_W-1:0]] = 1'b0;
          end
        end
        cpq_pkg::ACT_CLR_MARKS: act_nxt = '0;
        cpq_pkg::ACT_CLR_STORE: begin
          act_nxt   = '0;
          count_nxt = '0;
        end
        default: ;
      endcase
    end

    if (advance) begin
      if (last_idx) begin
        idx_nxt  = '0;
        pass_nxt = pass_r + 2'd1;
      end else begin
        idx_nxt = idx_r + cpq_pkg::IDX_W'(1);
      end
    end

    // hits trail by one so the final one can be flagged last
    if (state_r == cpq_pkg::ST_EMIT && emit_go) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_nxt.last  = 1'b0;
      end
      act_nxt[idx_r]      = 1'b1;
      pend_v_nxt          = 1'b1;
      pend_nxt.point_x    = mem_q_r.x;
      pend_nxt.point_y    = mem_q_r.y;
      pend_nxt.point_z    = mem_q_r.z;
      pend_nxt.point_id   = cpq_pkg::ID_W'(idx_r);
      pend_nxt.found      = 1'b1;
      pend_nxt.last       = 1'b0;
      pend_nxt.full_error = 1'b0;
    end

    if (state_r == cpq_pkg::ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      if (pend_v_r) begin
        out_nxt = pend_r;
      end else begin
        out_nxt = '0;
      end
      out_nxt.last = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpq_pkg::ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      pass_r      <= '0;
      act_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      act_r       <= act_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    prod_r <= sq_full[cpq_pkg::SQ_W-1:0];
    if (accept) begin
      qx_r   <= in_data.pos_x;
      qy_r   <= in_data.pos_y;
      qz_r   <= in_data.pos_z;
      qreg_r <= in_data.region;
      qtop_r <= cpq_pkg::DIFF_W'(in_data.pos_y) + $signed({2'b00, in_data.height});
    end
    if (state_r == cpq_pkg::ST_R2) begin
      r2_r <= prod_r;
    end
    if (state_r == cpq_pkg::ST_CHK) begin
      dx_r <= dx_w;
      dz_r <= dz_w;
    end
    if (state_r == cpq_pkg::ST_SQZ) begin
      acc_r <= prod_r;
    end
  end

endmodule

>>> hw/rtl/cpq_checker.sv
module cpq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input cpq_pkg::out_t  out_data
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a result without a point always closes its transaction
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.last)
    else $error("result without point not marked last");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.full_error |-> !out_data.found && out_data.last)
    else $error("full error on a point result");

  // the block works on one transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

endmodule

bind cylinder_point_query cpq_checker u_cpq_checker (.*);

>>> bench/tb_cylinder_point_query.sv
module tb_cylinder_point_query;
  import cpq_pkg::*;

  localparam int RAND_ITEMS = 400;
  localparam int LONG_HOLD  = 400;
  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] MAGMAX = '1;
  localparam int REG_TOP = (1 << REG_W) - 1;

  typedef struct {
    in_t              item;
    bit               typed;
    logic [ID_W-1:0]  id;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  // shadow copy of the point store
  logic signed [COORD_W-1:0] pt_x [MAX_POINTS];
  logic signed [COORD_W-1:0] pt_y [MAX_POINTS];
  logic signed [COORD_W-1:0] pt_z [MAX_POINTS];
  logic        [REG_W-1:0]   pt_region [MAX_POINTS];
  bit                        pt_active [MAX_POINTS];
  int                        pt_count = 0;

  out_t pending_results[$];
  int   errors = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  bit   hold_request = 1'b0;

  cylinder_point_query u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void cylinder_search(input in_t it, output out_t hits[$]);
    out_t   r;
    longint r2, ybot, ytop, dx, dz, py;
    int     target;
    hits = {};
    r = '0;
    case (it.action)
      ACT_LOAD: begin
        if (pt_count >= MAX_POINTS) begin
          r.full_error = 1'b1;
        end else begin
          pt_x[pt_count] = it.pos_x;
          pt_y[pt_count] = it.pos_y;
          pt_z[pt_count] = it.pos_z;
          pt_region[pt_count] = it.region;
          pt_active[pt_count] = 1'b0;
          r.point_id = ID_W'(pt_count);
          pt_count++;
        end
        r.last = 1'b1;
        hits = {hits, r};
      end
      ACT_CLR_MARKS, ACT_CLR_STORE: begin
        foreach (pt_active[i]) pt_active[i] = 1'b0;
        if (it.action == ACT_CLR_STORE) pt_count = 0;
        r.last = 1'b1;
        hits = {hits, r};
      end
      default: begin
        r2 = longint'(it.radius) * longint'(it.radius);
        ybot = longint'($signed(it.pos_y));
        ytop = ybot + longint'(it.height);
        // three passes: region below, centre region, region above
        for (int s = 0; s < 3; s++) begin
          target = int'(it.region) + s - 1;
          for (int i = 0; i < pt_count; i++) begin
            if (int'(pt_region[i]) != target || pt_active[i]) continue;
            py = longint'(pt_y[i]);
            if (py < ybot || py > ytop) continue;
            dx = longint'(pt_x[i]) - longint'($signed(it.pos_x));
            dz = longint'(pt_z[i]) - longint'($signed(it.pos_z));
            if (dx * dx + dz * dz > r2) continue;
            pt_active[i] = 1'b1;
            r = '0;
            r.point_x = pt_x[i];
            r.point_y = pt_y[i];
            r.point_z = pt_z[i];
            r.point_id = ID_W'(i);
            r.found = 1'b1;
            hits = {hits, r};
          end
        end
        if (hits.size() == 0) begin
          r = '0;
          r.last = 1'b1;
          hits = {hits, r};
        end else begin
          hits[hits.size()-1].last = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic in_t mk(input action_t a, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z,
                             input logic [MAG_W-1:0] r, input logic [MAG_W-1:0] h,
                             input logic [REG_W-1:0] g);
    in_t it;
    it.action = a;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.radius = r;
    it.height = h;
    it.region = g;
    return it;
  endfunction

  function automatic in_t rand_item();
    return mk(action_t'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), MAG_W'($urandom), MAG_W'($urandom), REG_W'($urandom));
  endfunction

  function automatic longint pick_centre();
    return longint'($urandom_range(0, 16760832)) - 64'sd8380416;
  endfunction

  function automatic int pick_region();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return REG_TOP;
      2: return int'($urandom_range(0, REG_TOP));
      default: return int'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] jitter(input longint base, input int span);
    return COORD_W'(base + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [REG_W-1:0] near_region(input int base);
    int g;
    g = base + int'($urandom_range(0, 2)) - 1;
    if ($urandom_range(0, 7) == 0) g = base + 2;
    if (g < 0) g = 0;
    if (g > REG_TOP) g = REG_TOP;
    return REG_W'(g);
  endfunction

  function automatic bit fits(input longint v);
    return v >= longint'(CMIN) && v <= longint'(CMAX);
  endfunction

  function automatic in_t cluster_load(input longint cx, input longint cy, input longint cz,
                                       input int r0);
    logic signed [COORD_W-1:0] y;
    y = ($urandom_range(0, 5) == 0) ? jitter(cy, 3000) : jitter(cy + 512, 512);
    return mk(ACT_LOAD, jitter(cx, 2048), y, jitter(cz, 2048), MAG_W'($urandom),
              MAG_W'($urandom), near_region(r0));
  endfunction

  function automatic in_t cluster_query(input longint cx, input longint cy, input longint cz,
                                        input int r0);
    return mk(ACT_QUERY, jitter(cx, 512), jitter(cy - 128, 128), jitter(cz, 512),
              MAG_W'($urandom_range(0, 3000)), MAG_W'($urandom_range(0, 1500)), REG_W'(r0));
  endfunction

  // bursts of back-to-back offers separated by random idle gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic put_item(input in_t it, input bit typed = 1'b0,
                          input logic [ID_W-1:0] tid = '0);
    out_t hits[$];
    out_t fixed;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cylinder_search(it, hits);
    if (typed) begin
      fixed = '0;
      fixed.point_id = tid;
      fixed.last = 1'b1;
      pending_results = {pending_results, fixed};
    end else begin
      foreach (hits[i]) pending_results = {pending_results, hits[i]};
    end
    items_sent++;
    pace();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: runs of free flow, light, heavy or full stalling, plus a requested long hold
  initial begin : stall_gen
    int  run_left;
    int  mode;
    int  hold_left;
    bit  nxt;
    run_left = 0;
    mode = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (run_left == 0) begin
        mode = $urandom_range(0, 3);
        run_left = $urandom_range(4, 40);
      end
      run_left--;
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else begin
        case (mode)
          0: nxt = 1'b0;
          1: nxt = ($urandom_range(0, 3) == 0);
          2: nxt = ($urandom_range(0, 3) != 0);
          default: nxt = 1'b1;
        endcase
      end
      out_stall <= nxt;
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %h", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.point_x !== want.point_x) begin
          $error("point_x: expected %0d, got %0d", $signed(want.point_x),
                 $signed(out_data.point_x));
          errors++;
        end
        if (out_data.point_y !== want.point_y) begin
          $error("point_y: expected %0d, got %0d", $signed(want.point_y),
                 $signed(out_data.point_y));
          errors++;
        end
        if (out_data.point_z !== want.point_z) begin
          $error("point_z: expected %0d, got %0d", $signed(want.point_z),
                 $signed(out_data.point_z));
          errors++;
        end
        if (out_data.point_id !== want.point_id) begin
          $error("point_id: expected %0d, got %0d", want.point_id, out_data.point_id);
          errors++;
        end
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          errors++;
        end
        if (out_data.full_error !== want.full_error) begin
          $error("full_error: expected %0d, got %0d", want.full_error, out_data.full_error);
          errors++;
        end
      end
    end
  end

  initial begin
    #200000000;
    $display("cylinder_point_query: mismatch");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir[$];
    in_t      it;
    longint   cx, cy, cz, qx, qy, qz;
    int       r0, qr, n, j, k, h, kind, fills;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extremes, region edges, inclusive bounds
    dir = {dir, dir_row_t'{mk(ACT_QUERY, 0, 0, 0, 256, 256, 0), 1'b1, 0}};
    dir = {dir, dir_row_t'{mk(ACT_CLR_MARKS, 0, 0, 0, 0, 0, 0), 1'b1, 0}};
    dir = {dir, dir_row_t'{mk(ACT_LOAD, CMAX, CMIN, CMAX, 0, 0, 0), 1'b1, 0}};
    dir = {dir, dir_row_t'{mk(ACT_LOAD, CMIN, CMAX, CMIN, MAGMAX, MAGMAX, REG_W'(REG_TOP)),
                           1'b1, 1}};
    dir = {dir, dir_row_t'{mk(ACT_LOAD, 0, 0, 0, 0, 0, 1), 1'b1, 2}};
    dir = {dir, dir_row_t'{mk(ACT_LOAD, 256, 256, 256, 0, 0, 2), 1'b1, 3}};
    dir = {dir, dir_row_t'{mk(ACT_LOAD, -256, 0, 0, 0, 0, 1), 1'b1, 4}};
    dir = {dir, dir_row_t'{mk(ACT_LOAD, 1000, -500, 1000, 0, 0, 5), 1'b1, 5}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, 0, 0, 0, 256, 256, 1), 1'b0, 0}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, 0, 0, 0, 256, 256, 1), 1'b0, 0}};
    dir = {dir, dir_row_t'{mk(ACT_CLR_MARKS, CMAX, CMAX, CMAX, MAGMAX, MAGMAX,
                              REG_W'(REG_TOP)), 1'b1, 0}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, CMAX, CMIN, CMAX, MAGMAX, MAGMAX, 0), 1'b0, 0}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, CMIN, CMAX, CMIN, 0, MAGMAX, REG_W'(REG_TOP)),
                           1'b0, 0}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, CMIN, CMAX, CMIN, 0, MAGMAX,
                              REG_W'(REG_TOP - 1)), 1'b0, 0}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, 1000, -500, 1000, 0, 0, 6), 1'b0, 0}};
    dir = {dir, dir_row_t'{mk(ACT_CLR_MARKS, 0, 0, 0, 0, 0, 0), 1'b1, 0}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, 1000, -501, 1000, 0, 1, 4), 1'b0, 0}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, 0, 0, 0, 255, 0, 1), 1'b0, 0}};
    dir = {dir, dir_row_t'{mk(ACT_CLR_STORE, 0, 0, 0, 0, 0, 0), 1'b1, 0}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, 0, 0, 0, MAGMAX, MAGMAX, 1), 1'b1, 0}};
    dir = {dir, dir_row_t'{mk(ACT_LOAD, 1, 2, 3, 0, 0, REG_W'(REG_TOP)), 1'b1, 0}};
    dir = {dir, dir_row_t'{mk(ACT_QUERY, 24'sh555555, 24'shAAAAAA, 24'sh555555,
                              23'h2AAAAA, 23'h555555, 10'h2AA), 1'b0, 0}};
    dir = {dir, dir_row_t'{mk(ACT_CLR_STORE, CMIN, CMIN, CMIN, MAGMAX, 0, 0), 1'b1, 0}};
    foreach (dir[i]) put_item(dir[i].item, dir[i].typed, dir[i].id);
    drain();

    items_sent = 0;
    fills = 0;
    while (items_sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (fills < 2 && items_sent >= 100 + 160 * fills) begin
        // fill the store, overflow it, then query while the receiver holds off
        fills++;
        drain();
        cx = pick_centre();
        cy = pick_centre();
        cz = pick_centre();
        r0 = pick_region();
        while (pt_count < MAX_POINTS) put_item(cluster_load(cx, cy, cz, r0));
        n = $urandom_range(1, 3);
        repeat (n) begin
          it = rand_item();
          it.action = ACT_LOAD;
          put_item(it);
        end
        hold_request = 1'b1;
        burst_left = 6;
        it = mk(ACT_QUERY, COORD_W'(cx), COORD_W'(cy - 100), COORD_W'(cz), 4000, 1500,
                REG_W'(r0));
        put_item(it);
        put_item(cluster_query(cx, cy, cz, r0));
        put_item(cluster_query(cx, cy, cz, r0));
        put_item(mk(ACT_CLR_MARKS, 0, 0, 0, 0, 0, 0));
        put_item(it);
      end else if (kind <= 5) begin
        cx = pick_centre();
        cy = pick_centre();
        cz = pick_centre();
        r0 = pick_region();
        if (pt_count > 40 || $urandom_range(0, 3) == 0) begin
          it = rand_item();
          it.action = ACT_CLR_STORE;
          put_item(it);
        end
        n = $urandom_range(1, 10);
        repeat (n) put_item(cluster_load(cx, cy, cz, r0));
        n = $urandom_range(1, 4);
        repeat (n) begin
          it = cluster_query(cx, cy, cz, r0);
          if (pt_count > 0 && $urandom_range(0, 3) == 0) begin
            // cylinder whose wall or cap passes exactly through a stored point
            j = $urandom_range(0, pt_count - 1);
            k = $urandom_range(0, 400);
            h = $urandom_range(0, 1000);
            qx = longint'(pt_x[j]) - 3 * k;
            qz = longint'(pt_z[j]) - 4 * k;
            qy = ($urandom_range(0, 1) == 1) ? longint'(pt_y[j]) : longint'(pt_y[j]) - h;
            qr = int'(pt_region[j]) + int'($urandom_range(0, 2)) - 1;
            if (fits(qx) && fits(qy) && fits(qz) && qr >= 0 && qr <= REG_TOP)
              it = mk(ACT_QUERY, COORD_W'(qx), COORD_W'(qy), COORD_W'(qz), MAG_W'(5 * k),
                      MAG_W'(h), REG_W'(qr));
          end
          put_item(it);
          if ($urandom_range(0, 3) == 0) put_item(mk(ACT_CLR_MARKS, 0, 0, 0, 0, 0, 0));
        end
        if ($urandom_range(0, 2) == 0) drain();
      end else if (kind <= 8) begin
        n = $urandom_range(1, 5);
        repeat (n) put_item(rand_item());
      end else begin
        it = rand_item();
        it.action = ($urandom_range(0, 1) == 1) ? ACT_CLR_MARKS : ACT_CLR_STORE;
        put_item(it);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("cylinder_point_query: match");
    else
      $display("cylinder_point_query: mismatch");
    $finish;
  end

endmodule
